// File: design/lwvm_pkg.sv
`default_nettype none

package lwvm_pkg;

    // frame geometry
    localparam int MAX_SIDE    = 256;
    localparam int HALF_WINDOW = 10;
    localparam int SIDE_W      = 9;
    localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int LCNT_W      = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int TOTAL_W     = 2 * SIDE_W;

    // field and accumulator widths
    localparam int PIX_W   = 16;
    localparam int PSQ_W   = 2 * PIX_W;
    localparam int FSUM_W  = 32;
    localparam int FSQ_W   = 48;
    localparam int DENSE_W = 17;
    localparam int SD_W    = 20;
    localparam int ROOT_W  = 32;
    localparam int DATA_W  = 64;
    localparam int WCNT_W  = $clog2(4 * HALF_WINDOW * HALF_WINDOW + 1);
    localparam int WSUM_W  = PIX_W + WCNT_W;
    localparam int WSQ_W   = PSQ_W + WCNT_W;

    // iteration counts of the shared unit
    localparam int MUL_STEPS  = 32;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // item and register codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD_SQ,
        ST_LOAD_ACC,
        ST_FIN_NQ,
        ST_FIN_SS,
        ST_FIN_D,
        ST_FIN_SQRT,
        ST_FIN_FILL,
        ST_FIN_BRIGHT,
        ST_FIN_DENSE,
        ST_Q_BASE,
        ST_Q_PADDR,
        ST_Q_SWEEP,
        ST_Q_DRAIN,
        ST_Q_PIX,
        ST_Q_PIXW,
        ST_Q_MEAN,
        ST_Q_CP,
        ST_Q_LL,
        ST_Q_D,
        ST_Q_SQRT,
        ST_Q_SD,
        ST_Q_EMIT
    } t_state;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v < SIDE_W'(2)) r = SIDE_W'(2);
        if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/lwvm_frame_mem.sv
`default_nettype none

module lwvm_frame_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [lwvm_pkg::ADDR_W-1:0]   i_waddr,
    input  wire logic [lwvm_pkg::PIX_W-1:0]    i_wdata,
    input  wire logic                          i_re,
    input  wire logic [lwvm_pkg::ADDR_W-1:0]   i_raddr,
    output logic      [lwvm_pkg::PIX_W-1:0]    o_rdata
);
    import lwvm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/lwvm_alu.sv
`default_nettype none

module lwvm_alu (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lwvm_pkg::t_alu_req            i_req,
    input  wire logic [lwvm_pkg::DATA_W-1:0]   i_opa,
    input  wire logic [lwvm_pkg::DATA_W-1:0]   i_opb,
    output logic                               o_done,
    output logic      [lwvm_pkg::DATA_W-1:0]   o_result
);
    import lwvm_pkg::*;

    localparam int REM_W = DATA_W + 2;

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_acc;
    logic [REM_W-1:0]  r_rem;

    logic [DATA_W-1:0] n_a;
    logic [DATA_W-1:0] n_b;
    logic [DATA_W-1:0] n_acc;
    logic [REM_W-1:0]  n_rem;

    logic [REM_W-1:0]  w_x;
    logic [REM_W-1:0]  w_y;
    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W:0]    w_res;
    logic              w_sub;
    logic              w_borrow;

    // one add/subtract serves every step: accumulate, trial divide, trial root
    always_comb begin
        w_sub    = 1'b1;
        w_x      = '0;
        w_y      = '0;
        w_rem_sh = '0;
        case (r_op)
            ALU_MUL: begin
                w_sub = 1'b0;
                w_x   = {2'b00, r_acc};
                w_y   = {2'b00, r_a};
            end
            ALU_DIV: begin
                w_rem_sh = {r_rem[REM_W-2:0], r_a[DATA_W-1]};
                w_x      = w_rem_sh;
                w_y      = {2'b00, r_b};
            end
            ALU_SQRT: begin
                w_rem_sh = {r_rem[REM_W-3:0], r_a[DATA_W-1 -: 2]};
                w_x      = w_rem_sh;
                w_y      = {r_acc, 2'b01};
            end
            default: ;
        endcase
        w_res    = w_sub ? ({1'b0, w_x} - {1'b0, w_y}) : ({1'b0, w_x} + {1'b0, w_y});
        w_borrow = w_res[REM_W];
    end

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_rem = r_rem;
        case (r_op)
            ALU_MUL: begin
                n_acc = r_b[0] ? w_res[DATA_W-1:0] : r_acc;
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
            end
            ALU_DIV: begin
                n_a   = {r_a[DATA_W-2:0], ~w_borrow};
                n_rem = w_borrow ? w_rem_sh : w_res[REM_W-1:0];
            end
            ALU_SQRT: begin
                n_a   = r_a << 2;
                n_rem = w_borrow ? w_rem_sh : w_res[REM_W-1:0];
                n_acc = {r_acc[DATA_W-2:0], ~w_borrow};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                case (i_req.op)
                    ALU_MUL:  r_step <= STEP_W'(MUL_STEPS - 1);
                    ALU_DIV:  r_step <= STEP_W'(DIV_STEPS - 1);
                    ALU_SQRT: r_step <= STEP_W'(SQRT_STEPS - 1);
                    default:  r_step <= STEP_W'(MUL_STEPS - 1);
                endcase
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_opa;
            r_b   <= i_opb;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        case (r_op)
            ALU_DIV: o_result = r_a;
            default: o_result = r_acc;
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// File: design/local_window_variance_map_top.sv
`default_nettype none

// channel   | handshake                    | payload
// ----------+------------------------------+--------------------------------------------
// input     | i_in_valid / o_in_ready      | i_opcode i_pixel_value i_row i_col
// output    | o_out_valid / i_out_ready    | o_valid_res o_local_mean o_local_sd
//           |                              | o_bright o_dense
// config    | i_cfg_we (no wait)           | i_cfg_index i_cfg_data
//
// one item at a time; a load writes the frame store and adds to the frame sums, and the
// load that completes the frame then works out frame statistics on the shared mul/div/sqrt unit
// a query sweeps its window (up to 400 pixels) through the single frame store read port
// and then uses the bit-serial shared unit; an out-of-frame query goes straight to its result
// synchronous active-low reset clears control, sums and thresholds, not the frame store
// a finished result waits in the output register while the next item is taken

module local_window_variance_map_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [lwvm_pkg::SIDE_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_opcode,
    input  wire logic [lwvm_pkg::PIX_W-1:0]     i_pixel_value,
    input  wire logic [7:0]                     i_row,
    input  wire logic [7:0]                     i_col,
    // result items
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_valid_res,
    output logic      [lwvm_pkg::PIX_W-1:0]     o_local_mean,
    output logic      [lwvm_pkg::SD_W-1:0]      o_local_sd,
    output logic                                o_bright,
    output logic                                o_dense
);
    import lwvm_pkg::*;

    localparam logic [SIDE_W-1:0] HW_S = SIDE_W'(HALF_WINDOW);

    // control state
    t_state               r_state;
    t_state               n_state;
    logic                 r_issued;
    logic                 r_out_valid;
    logic                 r_rd_vld;
    logic                 r_pv_vld;

    // configuration and frame statistics
    logic [SIDE_W-1:0]    r_width;
    logic [SIDE_W-1:0]    r_height;
    logic [LCNT_W-1:0]    r_load_count;
    logic [FSUM_W-1:0]    r_frame_sum;
    logic [FSQ_W-1:0]     r_frame_sq;
    logic [PIX_W-1:0]     r_fill;
    logic [PIX_W-1:0]     r_bright_thr;
    logic [DENSE_W-1:0]   r_dense_thr;
    logic                 r_frame_ready;

    // working registers
    logic [PIX_W-1:0]     r_ld_pix;
    logic [PSQ_W-1:0]     r_ld_sq;
    logic [7:0]           r_row;
    logic [7:0]           r_col;
    logic [SIDE_W-1:0]    r_r0;
    logic [SIDE_W-1:0]    r_r1;
    logic [SIDE_W-1:0]    r_c0;
    logic [SIDE_W-1:0]    r_c1;
    logic [SIDE_W-1:0]    r_rcur;
    logic [SIDE_W-1:0]    r_ccur;
    logic [ADDR_W-1:0]    r_base;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_paddr;
    logic [DATA_W-1:0]    r_t0;
    logic [DATA_W-1:0]    r_t1;
    logic [ROOT_W-1:0]    r_s;
    logic [PIX_W-1:0]     r_pv;
    logic [PSQ_W-1:0]     r_psq;
    logic [WSUM_W-1:0]    r_wsum;
    logic [WSQ_W-1:0]     r_wsq;
    logic [WCNT_W-1:0]    r_wcnt;
    logic                 r_q_ok;
    logic [PIX_W-1:0]     r_q_mean;
    logic [SD_W-1:0]      r_q_sd;
    logic                 r_q_bright;

    // output register
    logic                 r_o_valid_res;
    logic [PIX_W-1:0]     r_o_mean;
    logic [SD_W-1:0]      r_o_sd;
    logic                 r_o_bright;
    logic                 r_o_dense;

    // combinational
    logic [TOTAL_W-1:0]   w_total;
    logic                 w_in_acc;
    logic                 w_load_skip;
    logic                 w_load_last;
    logic [SIDE_W-1:0]    w_row9;
    logic [SIDE_W-1:0]    w_col9;
    logic [SIDE_W-1:0]    w_row_hi;
    logic [SIDE_W-1:0]    w_col_hi;
    logic [SIDE_W-1:0]    w_q_r0;
    logic [SIDE_W-1:0]    w_q_r1;
    logic [SIDE_W-1:0]    w_q_c0;
    logic [SIDE_W-1:0]    w_q_c1;
    logic                 w_q_ok;
    logic [FSUM_W+1:0]    w_two_sum;
    logic [FSUM_W+1:0]    w_three_s;
    logic                 w_fill_skip;
    logic                 w_col_end;
    logic                 w_sweep_last;
    logic                 w_out_free;
    logic                 w_alu_state;
    t_alu_req             w_alu_req;
    logic [DATA_W-1:0]    w_alu_a;
    logic [DATA_W-1:0]    w_alu_b;
    logic                 w_alu_done;
    logic [DATA_W-1:0]    w_alu_res;
    logic                 w_mem_we;
    logic                 w_mem_re;
    logic [ADDR_W-1:0]    w_mem_raddr;
    logic [PIX_W-1:0]     w_rdata;
    logic [PIX_W-1:0]     w_px;

    assign w_total     = TOTAL_W'(r_width) * TOTAL_W'(r_height);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_load_skip = r_frame_ready || (TOTAL_W'(r_load_count) >= w_total);
    assign w_load_last = (TOTAL_W'(r_load_count) + TOTAL_W'(1)) == w_total;

    // clipped window; upper bounds exclusive
    assign w_row9   = SIDE_W'(i_row);
    assign w_col9   = SIDE_W'(i_col);
    assign w_row_hi = w_row9 + HW_S;
    assign w_col_hi = w_col9 + HW_S;
    assign w_q_r0   = (w_row9 > HW_S) ? (w_row9 - HW_S) : '0;
    assign w_q_c0   = (w_col9 > HW_S) ? (w_col9 - HW_S) : '0;
    assign w_q_r1   = (w_row_hi > r_height - SIDE_W'(1)) ? (r_height - SIDE_W'(1)) : w_row_hi;
    assign w_q_c1   = (w_col_hi > r_width - SIDE_W'(1)) ? (r_width - SIDE_W'(1)) : w_col_hi;
    assign w_q_ok   = r_frame_ready && (w_row9 < r_height) && (w_col9 < r_width)
                      && (w_q_r1 > w_q_r0) && (w_q_c1 > w_q_c0);

    // fill value is zero when mean - 1.5 sd would go negative
    assign w_two_sum   = (FSUM_W+2)'({r_frame_sum, 1'b0});
    assign w_three_s   = (FSUM_W+2)'({r_s, 1'b0}) + (FSUM_W+2)'(r_s);
    assign w_fill_skip = (w_three_s >= w_two_sum);

    assign w_col_end    = (r_ccur == r_c1 - SIDE_W'(1));
    assign w_sweep_last = w_col_end && (r_rcur == r_r1 - SIDE_W'(1));
    assign w_out_free   = !r_out_valid || i_out_ready;

    // zero pixels read as the fill value
    assign w_px = (w_rdata == '0) ? r_fill : w_rdata;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_opcode == OP_LOAD) begin
                        n_state = w_load_skip ? ST_IDLE : ST_LOAD_SQ;
                    end else begin
                        n_state = w_q_ok ? ST_Q_BASE : ST_Q_EMIT;
                    end
                end
            end
            ST_LOAD_SQ:    n_state = ST_LOAD_ACC;
            ST_LOAD_ACC:   n_state = w_load_last ? ST_FIN_NQ : ST_IDLE;
            ST_FIN_NQ:     if (w_alu_done) n_state = ST_FIN_SS;
            ST_FIN_SS:     if (w_alu_done) n_state = ST_FIN_D;
            ST_FIN_D:      n_state = ST_FIN_SQRT;
            ST_FIN_SQRT:   if (w_alu_done) n_state = ST_FIN_FILL;
            ST_FIN_FILL:   if (w_fill_skip || w_alu_done) n_state = ST_FIN_BRIGHT;
            ST_FIN_BRIGHT: if (w_alu_done) n_state = ST_FIN_DENSE;
            ST_FIN_DENSE:  if (w_alu_done) n_state = ST_IDLE;
            ST_Q_BASE:     if (w_alu_done) n_state = ST_Q_PADDR;
            ST_Q_PADDR:    if (w_alu_done) n_state = ST_Q_SWEEP;
            ST_Q_SWEEP:    if (w_sweep_last) n_state = ST_Q_DRAIN;
            ST_Q_DRAIN:    if (!r_rd_vld && !r_pv_vld) n_state = ST_Q_PIX;
            ST_Q_PIX:      n_state = ST_Q_PIXW;
            ST_Q_PIXW:     n_state = ST_Q_MEAN;
            ST_Q_MEAN:     if (w_alu_done) n_state = ST_Q_CP;
            ST_Q_CP:       if (w_alu_done) n_state = ST_Q_LL;
            ST_Q_LL:       if (w_alu_done) n_state = ST_Q_D;
            ST_Q_D:        n_state = ST_Q_SQRT;
            ST_Q_SQRT:     if (w_alu_done) n_state = ST_Q_SD;
            ST_Q_SD:       if (w_alu_done) n_state = ST_Q_EMIT;
            ST_Q_EMIT:     if (w_out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // shared unit requests and operands
    always_comb begin
        w_alu_state = 1'b1;
        w_alu_req   = '{start: 1'b0, op: ALU_DIV};
        w_alu_a     = '0;
        w_alu_b     = '0;
        unique case (r_state)
            ST_FIN_NQ: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_frame_sq);
                w_alu_b      = DATA_W'(w_total);
            end
            ST_FIN_SS: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_frame_sum);
                w_alu_b      = DATA_W'(r_frame_sum);
            end
            ST_FIN_SQRT, ST_Q_SQRT: begin
                w_alu_req.op = ALU_SQRT;
                w_alu_a      = r_t0;
            end
            ST_FIN_FILL: begin
                w_alu_a = DATA_W'(w_two_sum - w_three_s);
                w_alu_b = DATA_W'({w_total, 1'b0});
            end
            ST_FIN_BRIGHT: begin
                w_alu_a = DATA_W'(r_frame_sum) + DATA_W'({r_s, 1'b0});
                w_alu_b = DATA_W'(w_total);
            end
            ST_FIN_DENSE: begin
                w_alu_a = DATA_W'({r_frame_sum, 1'b0}) + DATA_W'(r_s);
                w_alu_b = DATA_W'({w_total, 1'b0});
            end
            ST_Q_BASE: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_r0);
                w_alu_b      = DATA_W'(r_width);
            end
            ST_Q_PADDR: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_row);
                w_alu_b      = DATA_W'(r_width);
            end
            ST_Q_MEAN: begin
                w_alu_a = DATA_W'(r_wsum);
                w_alu_b = DATA_W'(r_wcnt);
            end
            ST_Q_CP: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_wsq);
                w_alu_b      = DATA_W'(r_wcnt);
            end
            ST_Q_LL: begin
                w_alu_req.op = ALU_MUL;
                w_alu_a      = DATA_W'(r_wsum);
                w_alu_b      = DATA_W'(r_wsum);
            end
            ST_Q_SD: begin
                w_alu_a = DATA_W'(r_s);
                w_alu_b = DATA_W'(r_wcnt);
            end
            default: w_alu_state = 1'b0;
        endcase
        w_alu_req.start = w_alu_state && !r_issued
                          && !((r_state == ST_FIN_FILL) && w_fill_skip);
    end

    // frame store port control
    always_comb begin
        w_mem_we    = w_in_acc && (i_opcode == OP_LOAD) && !w_load_skip;
        w_mem_re    = (r_state == ST_Q_SWEEP) || (r_state == ST_Q_PIX);
        w_mem_raddr = (r_state == ST_Q_PIX) ? r_paddr : r_addr;
    end

    lwvm_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_opa    (w_alu_a),
        .i_opb    (w_alu_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    lwvm_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata (i_pixel_value),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    // control and frame statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_issued      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_pv_vld      <= 1'b0;
            r_width       <= SIDE_W'(MAX_SIDE);
            r_height      <= SIDE_W'(MAX_SIDE);
            r_load_count  <= '0;
            r_frame_sum   <= '0;
            r_frame_sq    <= '0;
            r_fill        <= '0;
            r_bright_thr  <= '0;
            r_dense_thr   <= '0;
            r_frame_ready <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_Q_SWEEP);
            r_pv_vld <= r_rd_vld;

            if (w_alu_req.start) begin
                r_issued <= 1'b1;
            end else if (w_alu_done) begin
                r_issued <= 1'b0;
            end

            if ((r_state == ST_Q_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                // any register write starts a new frame
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= clamp_side(i_cfg_data);
                    CFG_HEIGHT: r_height <= clamp_side(i_cfg_data);
                    default: ;
                endcase
                r_load_count  <= '0;
                r_frame_sum   <= '0;
                r_frame_sq    <= '0;
                r_frame_ready <= 1'b0;
            end else begin
                case (r_state)
                    ST_LOAD_ACC: begin
                        r_frame_sum  <= r_frame_sum + FSUM_W'(r_ld_pix);
                        r_frame_sq   <= r_frame_sq + FSQ_W'(r_ld_sq);
                        r_load_count <= r_load_count + LCNT_W'(1);
                    end
                    ST_FIN_FILL: begin
                        if (w_fill_skip) begin
                            r_fill <= '0;
                        end else if (w_alu_done) begin
                            r_fill <= w_alu_res[PIX_W-1:0];
                        end
                    end
                    ST_FIN_BRIGHT: begin
                        if (w_alu_done) begin
                            r_bright_thr <= (|w_alu_res[DATA_W-1:PIX_W]) ? '1
                                                                      : w_alu_res[PIX_W-1:0];
                        end
                    end
                    ST_FIN_DENSE: begin
                        if (w_alu_done) begin
                            r_dense_thr   <= w_alu_res[DENSE_W-1:0];
                            r_frame_ready <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ld_pix <= i_pixel_value;
            r_row    <= i_row;
            r_col    <= i_col;
            r_r0     <= w_q_r0;
            r_r1     <= w_q_r1;
            r_c0     <= w_q_c0;
            r_c1     <= w_q_c1;
            r_q_ok   <= (i_opcode == OP_QUERY) && w_q_ok;
            r_wsum   <= '0;
            r_wsq    <= '0;
            r_wcnt   <= '0;
        end

        // window pixel pipeline: read, square, accumulate
        if (r_rd_vld) begin
            r_pv  <= w_px;
            r_psq <= PSQ_W'(w_px) * PSQ_W'(w_px);
        end
        if (r_pv_vld) begin
            r_wsum <= r_wsum + WSUM_W'(r_pv);
            r_wsq  <= r_wsq + WSQ_W'(r_psq);
            r_wcnt <= r_wcnt + WCNT_W'(1);
        end

        case (r_state)
            ST_LOAD_SQ: r_ld_sq <= PSQ_W'(r_ld_pix) * PSQ_W'(r_ld_pix);
            ST_FIN_NQ, ST_Q_CP: if (w_alu_done) r_t0 <= w_alu_res;
            ST_FIN_SS, ST_Q_LL: if (w_alu_done) r_t1 <= w_alu_res;
            ST_FIN_D:   r_t0 <= (r_t0 >= r_t1) ? (r_t0 - r_t1) : '0;
            ST_Q_D:     r_t0 <= (r_t0 >= r_t1) ? ((r_t0 - r_t1) << 8) : '0;
            ST_FIN_SQRT, ST_Q_SQRT: if (w_alu_done) r_s <= w_alu_res[ROOT_W-1:0];
            ST_Q_BASE:  if (w_alu_done) r_base <= w_alu_res[ADDR_W-1:0];
            ST_Q_PADDR: begin
                if (w_alu_done) begin
                    r_paddr <= w_alu_res[ADDR_W-1:0] + ADDR_W'(r_col);
                    r_addr  <= r_base + ADDR_W'(r_c0);
                    r_rcur  <= r_r0;
                    r_ccur  <= r_c0;
                end
            end
            ST_Q_SWEEP: begin
                if (w_col_end) begin
                    r_ccur <= r_c0;
                    r_rcur <= r_rcur + SIDE_W'(1);
                    r_base <= r_base + ADDR_W'(r_width);
                    r_addr <= r_base + ADDR_W'(r_width) + ADDR_W'(r_c0);
                end else begin
                    r_ccur <= r_ccur + SIDE_W'(1);
                    r_addr <= r_addr + ADDR_W'(1);
                end
            end
            ST_Q_PIXW:  r_q_bright <= (w_px > r_bright_thr);
            ST_Q_MEAN:  if (w_alu_done) r_q_mean <= w_alu_res[PIX_W-1:0];
            ST_Q_SD:    if (w_alu_done) r_q_sd <= w_alu_res[SD_W-1:0];
            ST_Q_EMIT: begin
                if (w_out_free) begin
                    r_o_valid_res <= r_q_ok;
                    r_o_mean      <= r_q_ok ? r_q_mean : '0;
                    r_o_sd        <= r_q_ok ? r_q_sd : '0;
                    r_o_bright    <= r_q_ok && r_q_bright;
                    r_o_dense     <= r_q_ok && (DENSE_W'(r_q_mean) > r_dense_thr);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_valid_res  = r_o_valid_res;
    assign o_local_mean = r_o_mean;
    assign o_local_sd   = r_o_sd;
    assign o_bright     = r_o_bright;
    assign o_dense      = r_o_dense;

endmodule

`default_nettype wire
